>>> rtl/cdw_pkg.sv
// shared types, constants and helper functions for the date check and weekday unit
`default_nettype none

package cdw_pkg;

  localparam logic [15:0] YEAR_MIN = 16'd2000;
  localparam logic [15:0] YEAR_MAX = 16'd2099;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_MAR = 4'd3;
  localparam logic [7:0]  MONTH_MAX = 8'd12;

  // checked date handed from the check stage to the encoder
  typedef struct packed {
    logic       ok;
    logic [6:0] yoff;
    logic [3:0] month;
    logic [4:0] day;
  } cdw_date_t;

  // length of a month, february as a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    begin
      unique case (m)
        4'd2:                      len = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // per-month weekday offset mod 7: 23*m/9, the march shift, the +3 and the
  // january/february borrow of one from the quarter-year term all folded in
  function automatic logic [2:0] month_ofs(input logic [3:0] m);
    logic [2:0] ofs;
    begin
      unique case (m)
        4'd1:    ofs = 3'd4;
        4'd2:    ofs = 3'd0;
        4'd3:    ofs = 3'd1;
        4'd4:    ofs = 3'd4;
        4'd5:    ofs = 3'd6;
        4'd6:    ofs = 3'd2;
        4'd7:    ofs = 3'd4;
        4'd8:    ofs = 3'd0;
        4'd9:    ofs = 3'd3;
        4'd10:   ofs = 3'd5;
        4'd11:   ofs = 3'd1;
        4'd12:   ofs = 3'd3;
        default: ofs = 3'd0;
      endcase
      return ofs;
    end
  endfunction

  // x mod 7 by reciprocal multiply and one correction
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [13:0] p;
    logic [5:0]  q;
    logic [7:0]  r;
    begin
      p = 14'(x) * 14'd36;
      q = p[13:8];
      r = x - 8'({2'b00, q} * 8'd7);
      if (r >= 8'd7) begin
        r = r - 8'd7;
      end
      return r[2:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/cdw_check.sv
// range and month-length check of one date, with the year offset from 2000
`default_nettype none

module cdw_check
  import cdw_pkg::*;
(
  input  wire logic [15:0] year,
  input  wire logic [7:0]  month,
  input  wire logic [7:0]  day,
  output cdw_date_t        date
);

  logic        year_ok;
  logic        month_ok;
  logic        day_ok;
  logic [15:0] yoff_full;
  logic        leap;
  logic [4:0]  mlen;

  assign year_ok   = (year >= YEAR_MIN) && (year <= YEAR_MAX);
  assign month_ok  = (month != 8'd0) && (month <= MONTH_MAX);
  assign yoff_full = year - YEAR_MIN;

  // within 2000..2099 the only century year is 2000, which is a leap year
  assign leap = (yoff_full[1:0] == 2'b00);

  always_comb begin
    mlen = month_len(month[3:0]);
    if (month[3:0] == MONTH_FEB && leap) begin
      mlen = 5'd29;
    end
  end

  assign day_ok = (day != 8'd0) && (day <= {3'b000, mlen});

  assign date.ok    = year_ok && month_ok && day_ok;
  assign date.yoff  = yoff_full[6:0];
  assign date.month = month[3:0];
  assign date.day   = day[4:0];

endmodule

`default_nettype wire

>>> rtl/cdw_encode.sv
// weekday and bcd encoding of a checked date
`default_nettype none

module cdw_encode
  import cdw_pkg::*;
(
  input  wire cdw_date_t   date,
  output logic             valid_res,
  output logic [2:0]       weekday,
  output logic [7:0]       year_bcd,
  output logic [4:0]       month_bcd,
  output logic [5:0]       day_bcd
);

  logic [6:0]  quarter;
  logic [7:0]  sum;
  logic [2:0]  wd;
  logic [17:0] ytens_p;
  logic [3:0]  ytens;
  logic [6:0]  yones;
  logic [4:0]  mb;
  logic [1:0]  dtens;
  logic [4:0]  dones;

  // year offset / 4, taken from the year before for january and february
  always_comb begin
    if (date.month < MONTH_MAR) begin
      quarter = (date.yoff + 7'd3) >> 2;
    end else begin
      quarter = date.yoff >> 2;
    end
  end

  assign sum = 8'(month_ofs(date.month)) + 8'(date.day) + 8'(date.yoff) + 8'(quarter);
  assign wd  = mod7(sum) + 3'd1;

  // tens of 0..99 by reciprocal multiply
  assign ytens_p = 18'(date.yoff) * 18'd205;
  assign ytens   = ytens_p[14:11];
  assign yones   = date.yoff - 7'({3'b000, ytens} * 7'd10);

  always_comb begin
    if (date.month >= 4'd10) begin
      mb = {1'b1, 4'(date.month - 4'd10)};
    end else begin
      mb = {1'b0, date.month};
    end
  end

  always_comb begin
    if (date.day >= 5'd30) begin
      dtens = 2'd3;
      dones = date.day - 5'd30;
    end else if (date.day >= 5'd20) begin
      dtens = 2'd2;
      dones = date.day - 5'd20;
    end else if (date.day >= 5'd10) begin
      dtens = 2'd1;
      dones = date.day - 5'd10;
    end else begin
      dtens = 2'd0;
      dones = date.day;
    end
  end

  assign valid_res = date.ok;
  assign weekday   = date.ok ? wd : 3'd0;
  assign year_bcd  = date.ok ? {ytens, yones[3:0]} : 8'd0;
  assign month_bcd = date.ok ? mb : 5'd0;
  assign day_bcd   = date.ok ? {dtens, dones[3:0]} : 6'd0;

endmodule

`default_nettype wire

>>> rtl/calendar_date_check_weekday_bcd_unit.sv
// top level of the date check, weekday and bcd unit
`default_nettype none

// Checks a date (year 2000..2099, month 1..12, day within the month, full
// leap rule) and returns the weekday (1=Monday..7=Sunday) with BCD forms of
// year mod 100, month and day; an invalid date returns valid_res=0 and zero
// fields. An item is taken when start is high and busy is low; busy is only
// high in reset and the cycle after, so one item can be taken every cycle.
// Each item is registered at the input, checked and encoded in combinational
// logic and registered again: its result appears with done after the input and
// output registers and lasts one cycle, as the receiver cannot stall.
module calendar_date_check_weekday_bcd_unit
  import cdw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] year,
  input  wire logic [7:0]  month,
  input  wire logic [7:0]  day,
  output logic             done,
  output logic             valid_res,
  output logic [2:0]       weekday,
  output logic [7:0]       year_bcd,
  output logic [4:0]       month_bcd,
  output logic [5:0]       day_bcd
);

  logic        in_vld;
  logic [15:0] year_q;
  logic [7:0]  month_q;
  logic [7:0]  day_q;
  cdw_date_t   date;
  logic        valid_next;
  logic [2:0]  weekday_next;
  logic [7:0]  year_bcd_next;
  logic [4:0]  month_bcd_next;
  logic [5:0]  day_bcd_next;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      year_q  <= year;
      month_q <= month;
      day_q   <= day;
    end
    if (in_vld) begin
      valid_res <= valid_next;
      weekday   <= weekday_next;
      year_bcd  <= year_bcd_next;
      month_bcd <= month_bcd_next;
      day_bcd   <= day_bcd_next;
    end
  end

  cdw_check u_check (
    .year  (year_q),
    .month (month_q),
    .day   (day_q),
    .date  (date)
  );

  cdw_encode u_encode (
    .date      (date),
    .valid_res (valid_next),
    .weekday   (weekday_next),
    .year_bcd  (year_bcd_next),
    .month_bcd (month_bcd_next),
    .day_bcd   (day_bcd_next)
  );

  // result comes with done after the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing after accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_vld))
    else $error("result strobe without item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (weekday == 3'd0 && year_bcd == 8'd0 &&
                              month_bcd == 5'd0 && day_bcd == 6'd0))
    else $error("invalid date with nonzero fields");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    (done && valid_res) |-> (weekday != 3'd0))
    else $error("valid date without weekday");

endmodule

`default_nettype wire
